// ----- hdl/jet_pkg.sv -----
// ----------------------------------------------------------------------------
// jet_pkg - Julia escape-time shared definitions
// Types, constants and helper functions for the escape-time engine and its
// iteration cells.
// ----------------------------------------------------------------------------
package jet_pkg;

    localparam int unsigned DATA_W    = 32;   // Q4.28 operand width
    localparam int unsigned ITER_W    = 9;    // width of the reported count
    localparam int unsigned MAX_ITER  = 256;  // iteration limit, 1..511 (fits ITER_W)
    localparam int unsigned NUM_CELLS = 2;    // iteration cells in the ring
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned SQ_W      = 40;   // Q8.32 square
    localparam int unsigned WIDE_W    = 40;   // next-z sum before saturation
    localparam int unsigned Q_FRAC    = 28;
    localparam int unsigned SQ_SHIFT  = 24;

    // internal counter must hold MAX_ITER itself and at least ITER_W bits
    localparam int unsigned CNT_RAW_W = $clog2(MAX_ITER + 1);
    localparam int unsigned CNT_W     = (CNT_RAW_W > ITER_W) ? CNT_RAW_W : ITER_W;

    // 4.0 in Q8.32, compared against the 41-bit sum of squares
    localparam logic [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(4) << 32;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_real;
        logic signed [DATA_W-1:0] start_imag;
    } jet_pixel_t;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              escaped;
    } jet_result_t;

    // one pixel in flight around the ring
    typedef struct packed {
        logic                     done;
        logic                     escaped;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } jet_token_t;

    typedef struct packed {
        logic       valid;
        jet_token_t tok;
    } jet_link_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic pos_ovf;
        logic neg_ovf;
        pos_ovf = !v[WIDE_W-1] && (|v[WIDE_W-2:DATA_W-1]);
        neg_ovf = v[WIDE_W-1] && !(&v[WIDE_W-2:DATA_W-1]);
        if (pos_ovf)
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

// ----- hdl/julia_escape_time.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time - Julia set escape-time engine
// Iterates z = z*z + c on a Q4.28 starting point and reports the iteration
// count and whether |z|^2 reached 4.
// ----------------------------------------------------------------------------
// One pixel is processed at a time. It circulates through a ring of NUM_CELLS
// iteration cells; each cell does one complex iteration in a registered
// multiply stage followed by the escape test and add/saturate stage.
// A pixel needing n iterations makes n+1 cell passes (the last one only
// finds it finished) and leaves only after the last cell, when the result
// register loads; while the result register is held by result_stall the
// finished pixel keeps making whole trips around the ring. A new pixel is
// taken at the edge after the result register loads.
// c_real and c_imag are register indexes 0 and 1 and must only be written
// while no pixel is in flight.
module julia_escape_time (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  jet_pkg::jet_pixel_t                 pixel,
    output logic                                result_valid,
    input  logic                                result_stall,
    output jet_pkg::jet_result_t                result,
    input  logic                                cfg_we,
    input  logic [jet_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jet_pkg::DATA_W-1:0]          cfg_data
);
    import jet_pkg::*;

    logic signed [DATA_W-1:0] c_real_reg;
    logic signed [DATA_W-1:0] c_imag_reg;

    logic                     busy_reg;
    logic                     busy_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    jet_result_t              result_reg;

    jet_link_t                link [NUM_CELLS+1];
    jet_link_t                ring_in;
    logic [NUM_CELLS-1:0]     occ;
    jet_link_t                exit_link;
    logic                     accept;
    logic                     deliver;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg <= '0;
            c_imag_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_C_REAL: c_real_reg <= cfg_data;
                CFG_C_IMAG: c_imag_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign exit_link = link[NUM_CELLS];
    assign accept    = pixel_valid && !busy_reg;
    // a finished token keeps circulating until the result register is free
    assign deliver   = exit_link.valid && exit_link.tok.done
                       && (!result_valid_reg || !result_stall);

    always_comb
    begin
        if (accept)
        begin
            ring_in.valid       = 1'b1;
            ring_in.tok.done    = 1'b0;
            ring_in.tok.escaped = 1'b0;
            ring_in.tok.count   = '0;
            ring_in.tok.re      = pixel.start_real;
            ring_in.tok.im      = pixel.start_imag;
        end
        else
        begin
            ring_in.valid = exit_link.valid && !deliver;
            ring_in.tok   = exit_link.tok;
        end
    end

    assign link[0] = ring_in;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        jet_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .c_real   (c_real_reg),
            .c_imag   (c_imag_reg),
            .link_in  (link[g]),
            .link_out (link[g+1]),
            .occupied (occ[g])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (deliver)
        begin
            busy_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (deliver)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            result_reg.iterations <= exit_link.tok.count[ITER_W-1:0];
            result_reg.escaped    <= exit_link.tok.escaped;
        end
    end

    assign pixel_stall  = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the ring carries exactly one token while busy and none otherwise
    a_ring_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(occ) && (busy_reg == (|occ)))
        else $error("ring occupancy does not match busy flag");

    // a result only appears as the pixel leaves the ring
    a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $fell(busy_reg))
        else $error("result raised without finishing a pixel");

    // a pixel that did not escape ran the full iteration limit
    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.escaped)
            |-> (result_reg.iterations == ITER_W'(MAX_ITER)))
        else $error("non-escaped result with short iteration count");

endmodule

// ----- hdl/jet_cell.sv -----
// ----------------------------------------------------------------------------
// jet_cell - one Julia iteration cell
// Stage 1 registers re*re, im*im and re*im. Stage 2 runs the escape test on
// the squares and either finishes the token or forms the next z, saturated.
// ----------------------------------------------------------------------------
module jet_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [jet_pkg::DATA_W-1:0] c_real,
    input  logic signed [jet_pkg::DATA_W-1:0] c_imag,
    input  jet_pkg::jet_link_t               link_in,
    output jet_pkg::jet_link_t               link_out,
    output logic                             occupied
);
    import jet_pkg::*;

    logic                     s1_valid_reg;
    jet_token_t               s1_tok_reg;
    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] ii_reg;
    logic signed [PROD_W-1:0] ri_reg;

    logic                     s2_valid_reg;
    jet_token_t               s2_tok_reg;
    jet_token_t               s2_tok_next;

    logic [SQ_W-1:0]          sq_re;
    logic [SQ_W-1:0]          sq_im;
    logic [SQ_W:0]            sq_sum;
    logic                     esc;
    logic signed [PROD_W-1:0] diff;
    logic signed [WIDE_W-1:0] nr;
    logic signed [WIDE_W-1:0] ni;

    // stage 1: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tok_reg <= link_in.tok;
        rr_reg     <= link_in.tok.re * link_in.tok.re;
        ii_reg     <= link_in.tok.im * link_in.tok.im;
        ri_reg     <= link_in.tok.re * link_in.tok.im;
    end

    // stage 2: escape test and next z
    always_comb
    begin
        // squares are non-negative and at most 2^62, so the top bit is zero
        sq_re  = rr_reg[PROD_W-1:SQ_SHIFT];
        sq_im  = ii_reg[PROD_W-1:SQ_SHIFT];
        sq_sum = {1'b0, sq_re} + {1'b0, sq_im};
        esc    = (sq_sum >= ESCAPE_LIMIT);

        // shifted products are signed and must be sign-extended
        diff = rr_reg - ii_reg;
        nr   = WIDE_W'(signed'(diff[PROD_W-1:Q_FRAC]))
             + {{(WIDE_W-DATA_W){c_real[DATA_W-1]}}, c_real};
        ni   = WIDE_W'(signed'(ri_reg[PROD_W-1:Q_FRAC-1]))
             + {{(WIDE_W-DATA_W){c_imag[DATA_W-1]}}, c_imag};

        s2_tok_next = s1_tok_reg;
        if (!s1_tok_reg.done)
        begin
            if (esc)
            begin
                s2_tok_next.done    = 1'b1;
                s2_tok_next.escaped = 1'b1;
            end
            else if (s1_tok_reg.count == CNT_W'(MAX_ITER))
            begin
                s2_tok_next.done    = 1'b1;
                s2_tok_next.escaped = 1'b0;
            end
            else
            begin
                s2_tok_next.re    = sat32(nr);
                s2_tok_next.im    = sat32(ni);
                s2_tok_next.count = s1_tok_reg.count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tok_reg <= s2_tok_next;
    end

    assign link_out.valid = s2_valid_reg;
    assign link_out.tok   = s2_tok_reg;
    assign occupied       = s1_valid_reg | s2_valid_reg;

endmodule
